### rtl/mck_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mck_pkg
// Shared types, unit codes and the ITU pattern table for the Morse keyer.
// -----------------------------------------------------------------------------
package mck_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic        key_level;
    logic [18:0] duration;
    logic        last;
  } out_t;

  localparam int UnitLenW = 16;
  localparam int DurW     = 19;
  localparam logic [UnitLenW-1:0] UnitLenReset = 16'd50;

  // Multiplier codes for the scaling unit
  typedef enum logic [1:0] {
    UNITS_1 = 2'd0,
    UNITS_3 = 2'd1,
    UNITS_7 = 2'd2
  } units_t;

  // Segment request from the sequencer to the scaling unit / output stage
  typedef struct packed {
    logic   valid;
    logic   level;
    units_t units;
    logic   last;
  } seg_req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] len;
    logic [4:0] bits;
  } pat_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  // 'A'..'Z' then '0'..'9'; bit i is element i in send order, 1 = dash
  localparam logic [2:0] PatLen [36] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] PatBits [36] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
    5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  function automatic pat_t pat_lookup(input logic [7:0] sym);
    pat_t       p;
    logic [7:0] off;
    logic [5:0] idx;
    p   = '0;
    off = 8'd0;
    idx = 6'd0;
    if (sym >= ChA && sym <= ChZ) begin
      off   = sym - ChA;
      idx   = off[5:0];
      p.hit = 1'b1;
    end else if (sym >= Ch0 && sym <= Ch9) begin
      off   = sym - Ch0 + 8'd26;
      idx   = off[5:0];
      p.hit = 1'b1;
    end
    if (p.hit) begin
      p.len  = PatLen[idx];
      p.bits = PatBits[idx];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/mck_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mck_scale
// Shared shift-add unit: scales the unit length by 1, 3 or 7 units.
// -----------------------------------------------------------------------------
module mck_scale
  import mck_pkg::*;
(
  input  wire logic [UnitLenW-1:0] unit_length,
  input  wire units_t              units,
  output logic      [DurW-1:0]     duration
);

  logic [DurW-1:0] len_ext;

  assign len_ext = {{(DurW-UnitLenW){1'b0}}, unit_length};

  always_comb begin
    unique case (units)
      UNITS_1: duration = len_ext;
      UNITS_3: duration = (len_ext << 1) + len_ext;
      UNITS_7: duration = (len_ext << 3) - len_ext;
      default: duration = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/mck_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mck_seq
// Segment sequencer: decodes one character and steps out its key segments,
// one per cycle while the output stage can take a beat.
// -----------------------------------------------------------------------------
module mck_seq
  import mck_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire in_t      in_data,
  input  wire logic     advance,
  output logic          busy,
  output seg_req_t      seg
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic       prev_r, prev_nxt;
  logic       space_r, space_nxt;
  logic       gap_r, gap_nxt;
  logic       sep_r, sep_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [4:0] bits_r, bits_nxt;

  pat_t pat;
  logic is_space;

  assign pat      = pat_lookup(in_data.symbol);
  assign is_space = (in_data.symbol == ChSpace);
  assign busy     = (state_r != ST_IDLE);

  // Segment selection; the letter gap goes in front of the character
  always_comb begin
    seg = '0;
    if (state_r == ST_EMIT) begin
      seg.valid = 1'b1;
      priority if (space_r) begin
        seg.units = UNITS_7;
        seg.last  = 1'b1;
      end else if (gap_r) begin
        seg.units = UNITS_3;
        seg.last  = (cnt_r == 3'd0);
      end else if (sep_r) begin
        seg.units = UNITS_1;
      end else begin
        seg.level = 1'b1;
        seg.units = bits_r[0] ? UNITS_3 : UNITS_1;
        seg.last  = (cnt_r == 3'd1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    prev_nxt  = prev_r;
    space_nxt = space_r;
    gap_nxt   = gap_r;
    sep_nxt   = sep_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          space_nxt = is_space;
          gap_nxt   = prev_r && !is_space;
          sep_nxt   = 1'b0;
          cnt_nxt   = (pat.hit && !is_space) ? pat.len : 3'd0;
          bits_nxt  = pat.bits;
          prev_nxt  = !is_space && !in_data.end_of_message;
          if (is_space || prev_r || pat.hit) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (advance) begin
          priority if (space_r) begin
            space_nxt = 1'b0;
          end else if (gap_r) begin
            gap_nxt = 1'b0;
          end else if (sep_r) begin
            sep_nxt = 1'b0;
          end else begin
            bits_nxt = bits_r >> 1;
            cnt_nxt  = cnt_r - 3'd1;
            sep_nxt  = (cnt_r > 3'd1);
          end
          if (seg.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= 1'b0;
      space_r <= 1'b0;
      gap_r   <= 1'b0;
      sep_r   <= 1'b0;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      space_r <= space_nxt;
      gap_r   <= gap_nxt;
      sep_r   <= sep_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !seg.valid)
    else $error("segment requested while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && seg.valid && seg.last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept running after the final segment");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd5)
    else $error("element count out of range");

  a_sep_needs_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && sep_r) |-> (cnt_r != 3'd0))
    else $error("element gap with no element after it");

endmodule
`default_nettype wire

### rtl/morse_code_keyer.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// morse_code_keyer
// ITU Morse keyer: one ASCII character in, a train of (level, duration) key
// segments out.
// -----------------------------------------------------------------------------
// One character is taken at a time. After it is accepted the sequencer emits
// one segment per cycle, while the output register can take a beat, through
// a single shift-add scaling unit. A digit with a leading letter gap sends
// the most segments and a space sends a single one. Durations are units
// times the unit length register (reset 50), which may be written whenever
// no character is in flight.
// -----------------------------------------------------------------------------
module morse_code_keyer
  import mck_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_t                 in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_t                     out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [UnitLenW-1:0] cfg_unit_length
);

  logic [UnitLenW-1:0] unit_length_r;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r;
  seg_req_t            seg;
  logic                busy;
  logic                start;
  logic                advance;
  logic [DurW-1:0]     duration;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  // output register frees up when empty or when its beat is taken
  assign advance   = !out_valid_r || !out_stall;

  mck_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .advance (advance),
    .busy    (busy),
    .seg     (seg)
  );

  mck_scale u_scale (
    .unit_length (unit_length_r),
    .units       (seg.units),
    .duration    (duration)
  );

  assign out_valid_nxt = (seg.valid && advance) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_length_r <= UnitLenReset;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unit_length_r <= cfg_unit_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seg.valid && advance) begin
      out_data_r.key_level <= seg.level;
      out_data_r.duration  <= duration;
      out_data_r.last      <= seg.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
